@@ rtl/local_std_filter_macros.svh @@
// assertion macros shared by the local standard deviation checker
`ifndef LOCAL_STD_FILTER_MACROS_SVH
`define LOCAL_STD_FILTER_MACROS_SVH

// same-cycle implication, sampled on the rising edge, off during reset
`define LSF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising edge, off during reset
`define LSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lsf_pkg.sv @@
// shared constants and widths of the local standard deviation filter
package lsf_pkg;

    localparam int MAX_LINE    = 2048;
    localparam int MAX_RADIUS  = 7;
    localparam int PIXEL_BITS  = 8;

    localparam int COL_W       = $clog2(MAX_LINE);
    localparam int LINE_W      = COL_W + 1;
    localparam int KMAX        = 2 * MAX_RADIUS + 1;
    localparam int SLOT_W      = $clog2(KMAX);
    localparam int HIST_DEPTH  = MAX_LINE * KMAX;
    localparam int HIST_AW     = SLOT_W + COL_W;

    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 16;
    localparam int RADIUS_W    = 3;
    localparam int ROW_W       = HEIGHT_W + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int STD_W       = 16;

    localparam int CSUM_W      = 12;
    localparam int CSQ_W       = 20;
    localparam int WSUM_W      = 16;
    localparam int WSQ_W       = 24;
    localparam int VAR_W       = 32;
    localparam int RAD_W       = VAR_W + 16;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int CNT_W       = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

endpackage

@@ rtl/local_std_filter.sv @@
// local standard deviation filter over a sliding square window, 8.8 output
//
//  port group   direction  handshake          payload
//  s_           in         s_valid / s_ready  s_pixel, s_frame_start
//  m_           out        m_valid / m_ready  m_std_value, m_frame_end
//  cfg_         in         cfg_we             cfg_index, cfg_data
//
// a transaction without a result takes a memory read, then an update
// a transaction with a result goes through the update, two multiplies, a
// subtract, a 24-step bit-serial root and a 24-step bit-serial divide
// the result sits in an output register, so the next transaction is taken
// while it waits; only a new result stalls until the old one is taken
// reset clears counters, window sums and control; no memory clearing pass
module local_std_filter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [lsf_pkg::PIXEL_BITS-1:0]    s_pixel,
    input  logic                              s_frame_start,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lsf_pkg::STD_W-1:0]         m_std_value,
    output logic                              m_frame_end,
    input  logic                              cfg_we,
    input  logic [lsf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lsf_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import lsf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SUB  = 3'd3;
    localparam logic [2:0] S_SQRT = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    localparam logic [4:0] LAST_STEP = 5'(ROOT_W - 1);

    typedef logic [CSQ_W+CSUM_W-1:0] col_word_t;

    logic [2:0]          state_reg, state_next;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [RADIUS_W-1:0] radius_reg;

    logic [COL_W-1:0]    col_cnt_reg;
    logic [ROW_W-1:0]    row_cnt_reg;
    logic [SLOT_W-1:0]   slot_reg;

    // item registers
    logic [PIXEL_BITS-1:0] pix_reg;
    logic [COL_W-1:0]      col_reg;
    logic [HIST_AW-1:0]    addr_reg;
    logic first_row_reg, full_reg, col0_reg, colgek_reg, emit_reg, fend_reg;

    // memories
    col_word_t           col_mem [MAX_LINE];
    logic [PIXEL_BITS-1:0] hist_mem [HIST_DEPTH];
    col_word_t           col_rd;
    logic [PIXEL_BITS-1:0] hist_rd;

    // shift line of the last column sums of this row
    col_word_t           sh_reg [KMAX];

    logic [WSUM_W-1:0]   ws_reg;
    logic [WSQ_W-1:0]    wsq_reg;
    logic [VAR_W-1:0]    a_reg, b_reg;
    logic [RAD_W-1:0]    x_reg;
    logic [ROOT_W+1:0]   rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [CNT_W-1:0]    drem_reg;
    logic [4:0]          step_reg;
    logic                fend_out_reg;

    logic [STD_W-1:0]    std_out_reg;
    logic                m_valid_reg;

    // effective geometry
    logic [RADIUS_W-1:0] r_eff;
    logic [SLOT_W-1:0]   two_r, k_val;
    logic [LINE_W-1:0]   w0, w_max, w_eff, line_len;
    logic [ROW_W-1:0]    h_eff, lines;
    logic [CNT_W-1:0]    cnt;

    always_comb begin
        r_eff    = (radius_reg == '0) ? RADIUS_W'(1) : radius_reg;
        two_r    = SLOT_W'({r_eff, 1'b0});
        k_val    = two_r + SLOT_W'(1);
        w0       = (width_reg == '0) ? LINE_W'(1) : LINE_W'(width_reg);
        w_max    = LINE_W'(MAX_LINE) - LINE_W'(two_r);
        w_eff    = (w0 > w_max) ? w_max : w0;
        line_len = w_eff + LINE_W'(two_r);
        h_eff    = (height_reg == '0) ? ROW_W'(1) : ROW_W'(height_reg);
        lines    = h_eff + ROW_W'(two_r);
        cnt      = CNT_W'(k_val) * CNT_W'(k_val);
    end

    // position of the incoming transaction and the counters after it
    logic                accept;
    logic [COL_W-1:0]    col_cur;
    logic [ROW_W-1:0]    row_cur;
    logic [SLOT_W-1:0]   slot_cur;
    logic [LINE_W-1:0]   col_inc;
    logic [ROW_W-1:0]    row_inc;
    logic [SLOT_W-1:0]   slot_inc;
    logic [COL_W-1:0]    col_cnt_next;
    logic [ROW_W-1:0]    row_cnt_next;
    logic [SLOT_W-1:0]   slot_next;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        col_cur  = (s_frame_start || (LINE_W'(col_cnt_reg) >= line_len)) ? '0 : col_cnt_reg;
        row_cur  = s_frame_start ? '0 : row_cnt_reg;
        slot_cur = (s_frame_start || (slot_reg >= k_val)) ? '0 : slot_reg;
        col_inc  = LINE_W'(col_cur) + LINE_W'(1);
        row_inc  = row_cur + ROW_W'(1);
        slot_inc = slot_cur + SLOT_W'(1);
        col_cnt_next = col_inc[COL_W-1:0];
        row_cnt_next = row_cur;
        slot_next    = slot_cur;
        if (col_inc >= line_len) begin
            col_cnt_next = '0;
            row_cnt_next = row_inc;
            slot_next    = (slot_inc >= k_val) ? '0 : slot_inc;
            if (row_inc >= lines) begin
                row_cnt_next = '0;
                slot_next    = '0;
            end
        end
    end

    // configuration registers and frame counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= WIDTH_W'(640);
            height_reg  <= HEIGHT_W'(480);
            radius_reg  <= RADIUS_W'(1);
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            slot_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_WIDTH: begin
                    width_reg   <= cfg_data[WIDTH_W-1:0];
                    col_cnt_reg <= '0;
                    row_cnt_reg <= '0;
                    slot_reg    <= '0;
                end
                REG_HEIGHT: begin
                    height_reg  <= cfg_data[HEIGHT_W-1:0];
                    col_cnt_reg <= '0;
                    row_cnt_reg <= '0;
                    slot_reg    <= '0;
                end
                REG_RADIUS: begin
                    radius_reg  <= cfg_data[RADIUS_W-1:0];
                    col_cnt_reg <= '0;
                    row_cnt_reg <= '0;
                    slot_reg    <= '0;
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            slot_reg    <= slot_next;
        end
    end

    // capture of the transaction and its position flags
    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg       <= s_pixel;
            col_reg       <= col_cur;
            addr_reg      <= {slot_cur, col_cur};
            first_row_reg <= (row_cur == '0);
            full_reg      <= (row_cur >= ROW_W'(k_val));
            col0_reg      <= (col_cur == '0);
            colgek_reg    <= (col_cur >= COL_W'(k_val));
            emit_reg      <= (row_cur >= ROW_W'(two_r)) && (col_cur >= COL_W'(two_r));
            fend_reg      <= (row_cur == lines - ROW_W'(1))
                             && (LINE_W'(col_cur) == line_len - LINE_W'(1));
        end
    end

    // column sum update
    logic [CSUM_W-1:0]       cs_sum, new_sum;
    logic [CSQ_W-1:0]        cs_sq, new_sq;
    logic [2*PIXEL_BITS-1:0] pp, old_sq;
    col_word_t               tap;
    logic [WSUM_W-1:0]       ws_next;
    logic [WSQ_W-1:0]        wsq_next;

    always_comb begin
        cs_sum = col_rd[CSUM_W-1:0];
        cs_sq  = col_rd[CSQ_W+CSUM_W-1:CSUM_W];
        pp     = pix_reg * pix_reg;
        old_sq = hist_rd * hist_rd;
        if (first_row_reg) begin
            new_sum = CSUM_W'(pix_reg);
            new_sq  = CSQ_W'(pp);
        end else if (!full_reg) begin
            new_sum = cs_sum + CSUM_W'(pix_reg);
            new_sq  = cs_sq + CSQ_W'(pp);
        end else begin
            new_sum = cs_sum + CSUM_W'(pix_reg) - CSUM_W'(hist_rd);
            new_sq  = cs_sq + CSQ_W'(pp) - CSQ_W'(old_sq);
        end
        tap = sh_reg[two_r];
        if (col0_reg) begin
            ws_next  = WSUM_W'(new_sum);
            wsq_next = WSQ_W'(new_sq);
        end else if (colgek_reg) begin
            ws_next  = ws_reg + WSUM_W'(new_sum) - WSUM_W'(tap[CSUM_W-1:0]);
            wsq_next = wsq_reg + WSQ_W'(new_sq) - WSQ_W'(tap[CSQ_W+CSUM_W-1:CSUM_W]);
        end else begin
            ws_next  = ws_reg + WSUM_W'(new_sum);
            wsq_next = wsq_reg + WSQ_W'(new_sq);
        end
    end

    // line store and column sum memories
    always_ff @(posedge aclk) begin
        if (accept) begin
            col_rd  <= col_mem[col_cur];
            hist_rd <= hist_mem[{slot_cur, col_cur}];
        end
        if (state_reg == S_UPD) begin
            col_mem[col_reg]   <= {new_sq, new_sum};
            hist_mem[addr_reg] <= pix_reg;
        end
    end

    // column sum shift line
    always_ff @(posedge aclk) begin
        if (state_reg == S_UPD) begin
            sh_reg[0] <= {new_sq, new_sum};
            for (int i = 1; i < KMAX; i++) begin
                sh_reg[i] <= sh_reg[i-1];
            end
        end
    end

    // window sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_reg  <= '0;
            wsq_reg <= '0;
        end else if (state_reg == S_UPD) begin
            ws_reg  <= ws_next;
            wsq_reg <= wsq_next;
        end
    end

    // root and divide steps
    logic [ROOT_W+1:0] rem_t, trial;
    logic [CNT_W:0]    drem_t;

    always_comb begin
        rem_t  = {rem_reg[ROOT_W-1:0], x_reg[RAD_W-1:RAD_W-2]};
        trial  = {root_reg, 2'b01};
        drem_t = {drem_reg, root_reg[ROOT_W-1]};
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_UPD: begin
                fend_out_reg <= fend_reg;
            end
            S_MUL: begin
                a_reg <= VAR_W'(cnt) * VAR_W'(wsq_reg);
                b_reg <= VAR_W'(ws_reg) * VAR_W'(ws_reg);
            end
            S_SUB: begin
                x_reg    <= {((a_reg > b_reg) ? a_reg - b_reg : VAR_W'(0)), 16'b0};
                rem_reg  <= '0;
                root_reg <= '0;
                step_reg <= '0;
            end
            S_SQRT: begin
                x_reg    <= {x_reg[RAD_W-3:0], 2'b00};
                step_reg <= step_reg + 5'd1;
                if (rem_t >= trial) begin
                    rem_reg  <= rem_t - trial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_t;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                if (step_reg == LAST_STEP) begin
                    step_reg <= '0;
                    drem_reg <= '0;
                end
            end
            S_DIV: begin
                // quotient bits shift into the freed low end of the root
                step_reg <= step_reg + 5'd1;
                if (drem_t >= {1'b0, cnt}) begin
                    drem_reg <= CNT_W'(drem_t - {1'b0, cnt});
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    drem_reg <= drem_t[CNT_W-1:0];
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer
    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept) state_next = S_UPD;
            S_UPD:  state_next = emit_reg ? S_MUL : S_IDLE;
            S_MUL:  state_next = S_SUB;
            S_SUB:  state_next = S_SQRT;
            S_SQRT: if (step_reg == LAST_STEP) state_next = S_DIV;
            S_DIV:  if (step_reg == LAST_STEP) state_next = S_OUT;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && out_free) begin
            std_out_reg <= (root_reg > ROOT_W'(16'hFFFF)) ? 16'hFFFF
                                                          : root_reg[STD_W-1:0];
            m_frame_end <= fend_out_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_std_value = std_out_reg;

endmodule

@@ rtl/lsf_checker.sv @@
// port-level checker for the local standard deviation filter, with its bind
`include "local_std_filter_macros.svh"

module lsf_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [lsf_pkg::STD_W-1:0]      m_std_value,
    input logic                           m_frame_end
);
    import lsf_pkg::*;

    // a result held back stays offered
    `LSF_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid, "result dropped while stalled")

    // a stalled result keeps its payload
    `LSF_ASSERT_NEXT(a_out_stable, m_valid && !m_ready,
        $stable(m_std_value) && $stable(m_frame_end), "result changed while stalled")

    // the block is busy in the cycle after each transaction
    `LSF_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready,
        "input taken twice in a row")

    // a new result only appears after the block has been busy
    `LSF_ASSERT_NOW(a_result_after_work, $rose(m_valid), $past(!s_ready),
        "result without preceding work")

endmodule

bind local_std_filter lsf_checker u_lsf_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_std_value (m_std_value),
    .m_frame_end (m_frame_end)
);
